// ===== sv/line_clip_rectangle_defines.svh =====
// assertion macros for the line clip rectangle block
`ifndef LINE_CLIP_RECTANGLE_DEFINES_SVH
`define LINE_CLIP_RECTANGLE_DEFINES_SVH

// same-cycle implication
`define LCR_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCR_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lcr_pkg.sv =====
// shared types and constants for the line clip rectangle block
`default_nettype none

package lcr_pkg;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int OUT_BITS     = 24;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TOP    = 2'd3;

    localparam logic signed [COORD_BITS-1:0] WINDOW_LEFT_RESET   = 16'sd0;
    localparam logic signed [COORD_BITS-1:0] WINDOW_BOTTOM_RESET = 16'sd0;
    localparam logic signed [COORD_BITS-1:0] WINDOW_RIGHT_RESET  = 16'sd32767;
    localparam logic signed [COORD_BITS-1:0] WINDOW_TOP_RESET    = 16'sd32767;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_word_t;

    typedef struct packed {
        logic                       visible;
        logic signed [OUT_BITS-1:0] clip_start_x;
        logic signed [OUT_BITS-1:0] clip_start_y;
        logic signed [OUT_BITS-1:0] clip_end_x;
        logic signed [OUT_BITS-1:0] clip_end_y;
    } out_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] bottom;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] top;
    } window_t;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] num;
        logic signed [DIFF_BITS-1:0] den;
    } frac_t;

    typedef struct packed {
        logic                         visible;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
        frac_t                        t_min;
        frac_t                        t_max;
    } task_t;

endpackage

`default_nettype wire

// ===== sv/line_clip_rectangle.sv =====
// top level of the line clip rectangle block
//
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      lcr_pkg::in_word_t  segment endpoints
// m_       out        m_valid / m_ready      lcr_pkg::out_word_t clipped segment
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data window edge
//
// one word per cycle in and out while m_ready is high; a word passes the front,
// queue and back (multiply, divider load, 24 divider steps, output register)
// the divider is one quotient bit per stage, 24 stages, four lanes in parallel
// reset is synchronous active low and clears valids, queue pointers and the window
// a stalled m_ channel holds the back pipeline; the four-word queue then fills
// and stalls the front, which drops s_ready
`default_nettype none

module line_clip_rectangle (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lcr_pkg::in_word_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lcr_pkg::out_word_t                   m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic signed [lcr_pkg::COORD_BITS-1:0] cfg_data
);

    lcr_pkg::window_t window_reg;
    logic             q_full, q_empty, push, pop;
    lcr_pkg::task_t   push_data, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg.left   <= lcr_pkg::WINDOW_LEFT_RESET;
            window_reg.bottom <= lcr_pkg::WINDOW_BOTTOM_RESET;
            window_reg.right  <= lcr_pkg::WINDOW_RIGHT_RESET;
            window_reg.top    <= lcr_pkg::WINDOW_TOP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lcr_pkg::REG_WINDOW_LEFT:   window_reg.left   <= cfg_data;
                lcr_pkg::REG_WINDOW_BOTTOM: window_reg.bottom <= cfg_data;
                lcr_pkg::REG_WINDOW_RIGHT:  window_reg.right  <= cfg_data;
                lcr_pkg::REG_WINDOW_TOP:    window_reg.top    <= cfg_data;
                default: ;
            endcase
        end
    end

    lcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .window    (window_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    lcr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    lcr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (q_empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== sv/lcr_front.sv =====
// front pipeline: edge distances, entry and exit parameters, visibility
`default_nettype none

module lcr_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcr_pkg::window_t window,
    input  logic             s_valid,
    output logic             s_ready,
    input  lcr_pkg::in_word_t s_data,
    input  logic             q_full,
    output logic             push,
    output lcr_pkg::task_t   push_data
);

    localparam int DB = lcr_pkg::DIFF_BITS;
    localparam int CB = lcr_pkg::COORD_BITS;
    localparam int PB = 2 * DB;

    typedef logic signed [DB-1:0] diff_t;
    typedef logic signed [PB-1:0] prod_t;

    typedef struct packed {
        lcr_pkg::frac_t ent;
        lcr_pkg::frac_t ext;
        logic           rej;
    } axis_t;

    function automatic diff_t sx(input logic signed [CB-1:0] v);
        return DB'(v);
    endfunction

    function automatic prod_t xprod(input diff_t a, input diff_t b);
        return PB'(a) * PB'(b);
    endfunction

    function automatic axis_t clip_axis(input diff_t qa, input diff_t pa,
                                        input diff_t qb, input diff_t pb);
        axis_t r;
        diff_t en_n;
        diff_t en_d;
        diff_t ex_n;
        diff_t ex_d;
        logic  have;
        r.ent = '{num: diff_t'(0), den: diff_t'(1)};
        r.ext = '{num: diff_t'(1), den: diff_t'(1)};
        r.rej = 1'b0;
        en_n  = '0;
        en_d  = '0;
        ex_n  = '0;
        ex_d  = '0;
        have  = 1'b1;
        if (pa > 0) begin
            en_n = -qa;
            en_d = pa;
            ex_n = qb;
            ex_d = -pb;
        end else if (pa < 0) begin
            en_n = -qb;
            en_d = pb;
            ex_n = qa;
            ex_d = -pa;
        end else begin
            have  = 1'b0;
            r.rej = (qa < 0) || (qb < 0);
        end
        if (have && (en_n > 0)) begin
            r.ent = '{num: en_n, den: en_d};
        end
        if (have && (ex_n < ex_d)) begin
            r.ext = '{num: ex_n, den: ex_d};
        end
        return r;
    endfunction

    logic en;

    // stage 1
    logic            v1_reg;
    logic signed [CB-1:0] x1_1_reg, y1_1_reg;
    diff_t           dx1_reg, dy1_reg;
    diff_t           q1_reg [4];
    diff_t           p1_reg [4];

    // stage 2
    logic            v2_reg;
    logic signed [CB-1:0] x1_2_reg, y1_2_reg;
    diff_t           dx2_reg, dy2_reg;
    axis_t           ax2_reg, ay2_reg;

    // stage 3
    logic            v3_reg;
    logic signed [CB-1:0] x1_3_reg, y1_3_reg;
    diff_t           dx3_reg, dy3_reg;
    axis_t           ax3_reg, ay3_reg;
    prod_t           pea_reg, peb_reg, pxa_reg, pxb_reg;

    // stage 4
    logic            v4_reg;
    logic signed [CB-1:0] x1_4_reg, y1_4_reg;
    diff_t           dx4_reg, dy4_reg;
    lcr_pkg::frac_t  tmin4_reg, tmax4_reg;
    logic            rej4_reg;

    // stage 5
    logic            v5_reg;
    logic signed [CB-1:0] x1_5_reg, y1_5_reg;
    diff_t           dx5_reg, dy5_reg;
    lcr_pkg::frac_t  tmin5_reg, tmax5_reg;
    logic            rej5_reg;
    prod_t           ca5_reg, cb5_reg;

    diff_t dx_c, dy_c;

    assign en      = !(v5_reg && q_full);
    assign s_ready = en;
    assign push    = v5_reg && !q_full;
    assign dx_c    = sx(s_data.end_x) - sx(s_data.start_x);
    assign dy_c    = sx(s_data.end_y) - sx(s_data.start_y);

    always_comb begin
        push_data.visible = !rej5_reg && !(ca5_reg > cb5_reg);
        push_data.x1      = x1_5_reg;
        push_data.y1      = y1_5_reg;
        push_data.dx      = dx5_reg;
        push_data.dy      = dy5_reg;
        push_data.t_min   = tmin5_reg;
        push_data.t_max   = tmax5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_1_reg  <= s_data.start_x;
            y1_1_reg  <= s_data.start_y;
            dx1_reg   <= dx_c;
            dy1_reg   <= dy_c;
            q1_reg[0] <= sx(s_data.start_x) - sx(window.left);
            p1_reg[0] <= dx_c;
            q1_reg[1] <= sx(window.top) - sx(s_data.start_y);
            p1_reg[1] <= -dy_c;
            q1_reg[2] <= sx(window.right) - sx(s_data.start_x);
            p1_reg[2] <= -dx_c;
            q1_reg[3] <= sx(s_data.start_y) - sx(window.bottom);
            p1_reg[3] <= dy_c;

            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            ax2_reg  <= clip_axis(q1_reg[0], p1_reg[0], q1_reg[2], p1_reg[2]);
            ay2_reg  <= clip_axis(q1_reg[3], p1_reg[3], q1_reg[1], p1_reg[1]);

            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            pea_reg  <= xprod(ax2_reg.ent.num, ay2_reg.ent.den);
            peb_reg  <= xprod(ay2_reg.ent.num, ax2_reg.ent.den);
            pxa_reg  <= xprod(ax2_reg.ext.num, ay2_reg.ext.den);
            pxb_reg  <= xprod(ay2_reg.ext.num, ax2_reg.ext.den);

            x1_4_reg  <= x1_3_reg;
            y1_4_reg  <= y1_3_reg;
            dx4_reg   <= dx3_reg;
            dy4_reg   <= dy3_reg;
            tmin4_reg <= (pea_reg > peb_reg) ? ax3_reg.ent : ay3_reg.ent;
            tmax4_reg <= (pxa_reg < pxb_reg) ? ax3_reg.ext : ay3_reg.ext;
            rej4_reg  <= ax3_reg.rej || ay3_reg.rej;

            x1_5_reg  <= x1_4_reg;
            y1_5_reg  <= y1_4_reg;
            dx5_reg   <= dx4_reg;
            dy5_reg   <= dy4_reg;
            tmin5_reg <= tmin4_reg;
            tmax5_reg <= tmax4_reg;
            rej5_reg  <= rej4_reg;
            ca5_reg   <= xprod(tmin4_reg.num, tmax4_reg.den);
            cb5_reg   <= xprod(tmax4_reg.num, tmin4_reg.den);
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcr_queue.sv =====
// four-word queue between the front and back pipelines
`default_nettype none

module lcr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lcr_pkg::task_t push_data,
    output logic           full,
    input  logic           pop,
    output lcr_pkg::task_t head,
    output logic           empty
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    lcr_pkg::task_t      mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;

    assign full  = (count_reg == (PTR_BITS+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcr_back.sv =====
// back pipeline: scaling, pipelined division and endpoint interpolation
`default_nettype none

`include "line_clip_rectangle_defines.svh"

module lcr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    input  lcr_pkg::task_t     head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lcr_pkg::out_word_t m_data
);

    localparam int DB  = lcr_pkg::DIFF_BITS;
    localparam int FB  = lcr_pkg::FRAC_BITS;
    localparam int OB  = lcr_pkg::OUT_BITS;
    localparam int QB  = lcr_pkg::COORD_BITS + lcr_pkg::FRAC_BITS;
    localparam int NB  = 2 * DB + FB + 1;
    localparam int LANES = 4;

    typedef struct packed {
        logic [2*DB-1:0] mag;
        logic [DB-1:0]   den;
        logic            neg;
        logic [OB-1:0]   base;
    } mul_t;

    typedef struct packed {
        logic [DB-1:0] rem;
        logic [QB-1:0] acc;
        logic [DB-1:0] den;
        logic          neg;
        logic [OB-1:0] base;
    } lane_t;

    function automatic lane_t div_step(input lane_t a);
        lane_t       r;
        logic [DB:0] t;
        r = a;
        t = {a.rem, a.acc[QB-1]};
        if (t >= {1'b0, a.den}) begin
            t     = t - {1'b0, a.den};
            r.acc = {a.acc[QB-2:0], 1'b1};
        end else begin
            r.acc = {a.acc[QB-2:0], 1'b0};
        end
        r.rem = t[DB-1:0];
        return r;
    endfunction

    function automatic lane_t div_load(input mul_t m);
        lane_t       r;
        logic [NB-1:0] n;
        n      = (NB'(m.mag) << FB) + NB'(m.den >> 1);
        r.rem  = DB'(n[NB-1:QB]);
        r.acc  = n[QB-1:0];
        r.den  = m.den;
        r.neg  = m.neg;
        r.base = m.base;
        return r;
    endfunction

    function automatic mul_t lane_mul(input logic signed [DB-1:0] d,
                                      input lcr_pkg::frac_t t,
                                      input logic signed [lcr_pkg::COORD_BITS-1:0] s);
        mul_t          r;
        logic [DB-1:0] ad;
        ad     = d[DB-1] ? DB'(-d) : DB'(d);
        r.mag  = (2*DB)'(ad) * (2*DB)'(t.num);
        r.den  = t.den;
        r.neg  = d[DB-1];
        r.base = OB'(s) << FB;
        return r;
    endfunction

    function automatic logic [OB-1:0] lane_out(input lane_t a);
        return a.neg ? a.base - OB'(a.acc) : a.base + OB'(a.acc);
    endfunction

    logic en;

    logic  mv_reg;
    logic  mvis_reg;
    mul_t  mul_reg [LANES];

    logic  dv_reg   [QB+1];
    logic  dvis_reg [QB+1];
    lane_t lane_reg [QB+1][LANES];

    logic               out_vld_reg;
    lcr_pkg::out_word_t out_reg;

    assign en      = !out_vld_reg || m_ready;
    assign pop     = en && !empty;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            mv_reg    <= !empty;
            dv_reg[0] <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mvis_reg    <= head.visible;
            mul_reg[0]  <= lane_mul(head.dx, head.t_min, head.x1);
            mul_reg[1]  <= lane_mul(head.dy, head.t_min, head.y1);
            mul_reg[2]  <= lane_mul(head.dx, head.t_max, head.x1);
            mul_reg[3]  <= lane_mul(head.dy, head.t_max, head.y1);
            dvis_reg[0] <= mvis_reg;
            for (int l = 0; l < LANES; l++) begin
                lane_reg[0][l] <= div_load(mul_reg[l]);
            end
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvis_reg[k] <= dvis_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    lane_reg[k][l] <= div_step(lane_reg[k-1][l]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.visible <= dvis_reg[QB];
            if (dvis_reg[QB]) begin
                out_reg.clip_start_x <= lane_out(lane_reg[QB][0]);
                out_reg.clip_start_y <= lane_out(lane_reg[QB][1]);
                out_reg.clip_end_x   <= lane_out(lane_reg[QB][2]);
                out_reg.clip_end_y   <= lane_out(lane_reg[QB][3]);
            end else begin
                out_reg.clip_start_x <= '0;
                out_reg.clip_start_y <= '0;
                out_reg.clip_end_x   <= '0;
                out_reg.clip_end_y   <= '0;
            end
        end
    end

    `LCR_ASSERT_IMP(a_reject_zero, aclk, aresetn, m_valid && !m_data.visible, m_data.clip_start_x == '0 && m_data.clip_start_y == '0 && m_data.clip_end_x == '0 && m_data.clip_end_y == '0, "rejected word carries non-zero coordinates")
    `LCR_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    `LCR_ASSERT_NXT(a_pop_enters, aclk, aresetn, pop, mv_reg, "popped word did not enter the multiply stage")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the line clip rectangle block
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int CB = lcr_pkg::COORD_BITS;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lcr_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lcr_pkg::out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lcr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic signed [CB-1:0] cfg_data = '0;

    int idle_cycles = 0;
    int sent_count = 0;
    int hold_cycles = 0;
    bit drive_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_clip_rectangle DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    class clip_scoreboard;
        lcr_pkg::out_word_t pending[$];
        lcr_pkg::window_t win;
        int error_count;
        int visible_count;

        function new();
            win.left = lcr_pkg::WINDOW_LEFT_RESET;
            win.bottom = lcr_pkg::WINDOW_BOTTOM_RESET;
            win.right = lcr_pkg::WINDOW_RIGHT_RESET;
            win.top = lcr_pkg::WINDOW_TOP_RESET;
            error_count = 0;
            visible_count = 0;
        endfunction

        task report(input string what, input longint got, input longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            error_count++;
        endtask

        function void set_edge(logic [lcr_pkg::CFG_IDX_BITS-1:0] idx, logic signed [CB-1:0] v);
            case (idx)
                lcr_pkg::REG_WINDOW_LEFT: win.left = v;
                lcr_pkg::REG_WINDOW_BOTTOM: win.bottom = v;
                lcr_pkg::REG_WINDOW_RIGHT: win.right = v;
                default: win.top = v;
            endcase
        endfunction

        function logic [lcr_pkg::OUT_BITS-1:0] lerp(longint s, longint d, longint tn, longint td);
            longint mag, q, r;
            mag = (d < 0 ? -d : d) * tn;
            q = ((mag <<< lcr_pkg::FRAC_BITS) + (td >>> 1)) / td;
            r = (s <<< lcr_pkg::FRAC_BITS) + (d < 0 ? -q : q);
            return r[lcr_pkg::OUT_BITS-1:0];
        endfunction

        function void note_segment(lcr_pkg::in_word_t w);
            longint x1, y1, dx, dy, n0, d0, n1, d1, q, p;
            longint qv[4], pv[4];
            bit ok;
            lcr_pkg::out_word_t r;
            x1 = w.start_x; y1 = w.start_y;
            dx = longint'(w.end_x) - x1; dy = longint'(w.end_y) - y1;
            qv[0] = x1 - win.left;  pv[0] = dx;
            qv[1] = win.top - y1;   pv[1] = -dy;
            qv[2] = win.right - x1; pv[2] = -dx;
            qv[3] = y1 - win.bottom; pv[3] = dy;
            n0 = 0; d0 = 1; n1 = 1; d1 = 1; ok = 1'b1;
            for (int e = 0; e < 4 && ok; e++) begin
                q = qv[e]; p = pv[e];
                if (p == 0) begin
                    if (q < 0) ok = 1'b0;
                    continue;
                end
                if (p > 0) begin
                    if (-q * d0 > n0 * p) begin n0 = -q; d0 = p; end
                end else begin
                    if (q * d1 < n1 * -p) begin n1 = q; d1 = -p; end
                end
                if (n0 * d1 > n1 * d0) ok = 1'b0;
            end
            r = '0;
            if (ok) begin
                r.visible = 1'b1;
                r.clip_start_x = lerp(x1, dx, n0, d0);
                r.clip_start_y = lerp(y1, dy, n0, d0);
                r.clip_end_x = lerp(x1, dx, n1, d1);
                r.clip_end_y = lerp(y1, dy, n1, d1);
            end
            pending.push_back(r);
        endfunction

        task check_result(lcr_pkg::out_word_t got);
            lcr_pkg::out_word_t want;
            if (pending.size() == 0) begin
                report("unexpected word", got.visible, -1);
                return;
            end
            want = pending.pop_front();
            if (got.visible) visible_count++;
            if (got.visible !== want.visible) report("visible", got.visible, want.visible);
            if (got.clip_start_x !== want.clip_start_x)
                report("clip_start_x", got.clip_start_x, want.clip_start_x);
            if (got.clip_start_y !== want.clip_start_y)
                report("clip_start_y", got.clip_start_y, want.clip_start_y);
            if (got.clip_end_x !== want.clip_end_x)
                report("clip_end_x", got.clip_end_x, want.clip_end_x);
            if (got.clip_end_y !== want.clip_end_y)
                report("clip_end_y", got.clip_end_y, want.clip_end_y);
        endtask
    endclass

    clip_scoreboard clip_sb = new();

    task automatic write_edge(logic [lcr_pkg::CFG_IDX_BITS-1:0] idx, logic signed [CB-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        clip_sb.set_edge(idx, v);
    endtask

    task automatic set_window(int l, int b, int r, int t);
        write_edge(lcr_pkg::REG_WINDOW_LEFT, CB'(l));
        write_edge(lcr_pkg::REG_WINDOW_BOTTOM, CB'(b));
        write_edge(lcr_pkg::REG_WINDOW_RIGHT, CB'(r));
        write_edge(lcr_pkg::REG_WINDOW_TOP, CB'(t));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (clip_sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_segment(int x1, int y1, int x2, int y2, bit no_gap = 1'b0);
        lcr_pkg::in_word_t w;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        w.start_x = CB'(x1); w.start_y = CB'(y1); w.end_x = CB'(x2); w.end_y = CB'(y2);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        clip_sb.note_segment(w);
        sent_count++;
    endtask

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int coord(int lo, int hi);
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return rand_in(-32768, 32767);
            default: return rand_in(lo, hi);
        endcase
    endfunction

    task automatic random_segments(int n, int lo, int hi, bit burst);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_segment(coord(lo, hi), coord(lo, hi), coord(lo, hi), coord(lo, hi), burst);
            else if ($urandom_range(0, 7) == 0) begin
                int x, y;
                x = coord(lo, hi); y = coord(lo, hi);
                send_segment(x, y, $urandom_range(0, 1) ? x : coord(lo, hi), y, burst);
            end else
                send_segment(rand_in(lo - 200, hi + 200), rand_in(lo - 200, hi + 200),
                             rand_in(lo - 200, hi + 200), rand_in(lo - 200, hi + 200),
                             burst);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: defaults, then a small window
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, 32767, -32768, -32768);
        send_segment(100, 100, 100, 100);
        send_segment(-5, 100, -5, 100);
        send_segment(-10, 50, 200, 50);
        send_segment(-32768, 32767, 32767, -32768);
        s_valid <= 1'b0;
        wait_drained();
        set_window(-100, -50, 100, 50);
        send_segment(-200, 0, 200, 0);
        send_segment(0, -200, 0, 200);
        send_segment(-200, -200, 200, 200);
        send_segment(-300, 100, 300, 100);
        send_segment(-300, 50, 300, 50);
        send_segment(-101, -200, -101, 200);
        send_segment(-100, -50, 100, 50);
        send_segment(0, 0, 0, 0);
        send_segment(-150, 60, 150, -70);
        send_segment(-200, 0, 0, 200);
        send_segment(7, 3, -9, 11);
        s_valid <= 1'b0;
        wait_drained();
        // inverted window rejects everything
        set_window(10, 10, -10, -10);
        send_segment(0, 0, 0, 0);
        send_segment(-100, -100, 100, 100);
        s_valid <= 1'b0;
        wait_drained();
        set_window(-32768, -32768, 32767, 32767);
        random_segments(230, -32768, 32767, 1'b0);
        wait_drained();
        set_window(-1000, -700, 1200, 900);
        random_segments(350, -1200, 1400, 1'b0);
        wait_drained();
        set_window(rand_in(-300, -100), rand_in(-300, -100),
                   rand_in(100, 300), rand_in(100, 300));
        // burst while the receiver holds off
        hold_cycles = 300;
        random_segments(150, -500, 500, 1'b1);
        random_segments(250, -500, 500, 1'b0);
        wait_drained();
        set_window(32767, 32767, 32767, 32767);
        random_segments(50, 32700, 32767, 1'b0);
        wait_drained();
        set_window(-32768, -32768, -32768, -32768);
        random_segments(50, -32768, -32700, 1'b0);
        wait_drained();
        drive_done = 1'b1;
    end

    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            clip_sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            hold_cycles > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (drive_done || idle_cycles >= WATCHDOG_LIMIT);
        if (!drive_done) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
        end else begin
            $display("clipped %0d segments against several windows, %0d visible",
                     sent_count, clip_sb.visible_count);
            if (clip_sb.error_count == 0 && clip_sb.pending.size() == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/lcr_pkg.sv
sv/lcr_front.sv
sv/lcr_queue.sv
sv/lcr_back.sv
sv/line_clip_rectangle.sv
tb/tb.sv
